[hw/rtl/spdxc_pkg.sv]
// Shared constants, types and helper functions of the sync packet deframer.
package spdxc_pkg;

  // Header sizes in bytes
  localparam int LONG_HEADER_BYTES  = 44;
  localparam int SHORT_HEADER_BYTES = 16;

  // One XOR snapshot per 16-bit word of the longest header
  localparam int SNAP_DEPTH = LONG_HEADER_BYTES / 2;
  localparam int SNAP_IDX_W = $clog2(SNAP_DEPTH);

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LEN_OFFSET  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LEN_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_ID_OFFSET   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_ID_OFFSET  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PACKET_LEN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SUPPRESS_GOOD    = 3'd5;

  localparam logic [15:0] MAX_PACKET_LEN_RESET = 16'd4096;

  // Frame status codes
  localparam logic [2:0] STAT_NONE      = 3'd0;
  localparam logic [2:0] STAT_GOOD      = 3'd1;
  localparam logic [2:0] STAT_BAD_CHECK = 3'd2;
  localparam logic [2:0] STAT_ZERO_LEN  = 3'd3;
  localparam logic [2:0] STAT_OVERSIZE  = 3'd4;
  localparam logic [2:0] STAT_SUPPRESS  = 3'd5;
  localparam logic [2:0] STAT_STRAY     = 3'd6;

  // Sync and type bytes
  localparam logic [7:0] SYNC_LONG_A = 8'hAB;
  localparam logic [7:0] SYNC_LONG_B = 8'hBB;
  localparam logic [7:0] SYNC_SHORT  = 8'hDA;
  localparam logic [7:0] TYPE_BYTE_0 = 8'hAB;
  localparam logic [7:0] TYPE_BYTE_1 = 8'hBC;
  localparam logic [7:0] TYPE_BYTE_2 = 8'hCD;
  localparam logic [7:0] TYPE_BYTE_3 = 8'hDE;
  localparam logic [7:0] CHECK_SEED_HIGH = 8'hDA;

  typedef struct packed {
    logic [5:0]  long_len_offset;
    logic [3:0]  short_len_offset;
    logic [5:0]  long_id_offset;
    logic [3:0]  short_id_offset;
    logic [15:0] max_packet_len;
    logic        suppress_good;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        in_frame;
    logic        frame_end;
    logic [2:0]  status;
    logic [15:0] frame_length;
    logic [15:0] frame_id;
    logic [1:0]  type_code;
    logic [15:0] computed_check;
  } result_t;

  // Type byte belonging to a type code
  function automatic logic [7:0] type_byte(input logic [1:0] code);
    logic [7:0] tb;
    case (code)
      2'd0:    tb = TYPE_BYTE_0;
      2'd1:    tb = TYPE_BYTE_1;
      2'd2:    tb = TYPE_BYTE_2;
      default: tb = TYPE_BYTE_3;
    endcase
    return tb;
  endfunction

  // Seed folded into the check word at frame end
  function automatic logic [15:0] check_seed(input logic [1:0] code);
    return {CHECK_SEED_HIGH, type_byte(code)};
  endfunction

endpackage

[hw/rtl/spdxc_parser.sv]
// Frame parser: parse state, header field capture, XOR check and per-byte result.
module spdxc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  spdxc_pkg::cfg_t   cfg,
  output spdxc_pkg::result_t res
);
  import spdxc_pkg::*;

  localparam logic [1:0] PH_SYNC   = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_HEADER = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  // Merge one byte into a big-endian 16-bit field found at offset off
  function automatic logic [15:0] field_byte(input logic [15:0] cur, input logic [15:0] off,
                                             input logic [15:0] idx, input logic [7:0] b);
    logic [15:0] r;
    r = cur;
    if (idx == off) begin
      r = {b, cur[7:0]};
    end else if (idx == off + 16'd1) begin
      r = {cur[15:8], b};
    end
    return r;
  endfunction

  logic [1:0]  parse_phase, parse_phase_next;
  logic        long_header, long_header_next;
  logic [1:0]  kind, kind_next;
  logic [15:0] stored_count, stored_count_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] id_value, id_value_next;
  logic [15:0] expected_check, expected_check_next;
  logic [15:0] running_xor, running_xor_next;
  logic [7:0]  pending_high, pending_high_next;

  logic [15:0] header_xor_snap [SNAP_DEPTH];
  logic                  snap_we;
  logic [SNAP_IDX_W-1:0] snap_idx;

  logic [15:0] hdr_bytes;
  logic [15:0] last_word;
  logic [5:0]  len_off;
  logic [5:0]  id_off;
  logic [15:0] word_in;
  logic [15:0] xor_upd;
  logic [15:0] n_words;
  logic [15:0] chk;
  logic [16:0] end_lhs;

  always_comb begin
    // hold state by default
    parse_phase_next    = parse_phase;
    long_header_next    = long_header;
    kind_next           = kind;
    stored_count_next   = stored_count;
    length_value_next   = length_value;
    id_value_next       = id_value;
    expected_check_next = expected_check;
    running_xor_next    = running_xor;
    pending_high_next   = pending_high;
    snap_we             = 1'b0;
    snap_idx            = stored_count[SNAP_IDX_W:1];

    hdr_bytes = long_header ? 16'(LONG_HEADER_BYTES) : 16'(SHORT_HEADER_BYTES);
    last_word = (hdr_bytes >> 1) - 16'd1;
    len_off   = long_header ? cfg.long_len_offset : {2'b00, cfg.short_len_offset};
    id_off    = long_header ? cfg.long_id_offset : {2'b00, cfg.short_id_offset};
    word_in   = {pending_high, rx_byte};
    xor_upd   = running_xor;
    n_words   = 16'd0;
    chk       = 16'd0;
    end_lhs   = 17'd0;

    res.echo_byte      = rx_byte;
    res.in_frame       = 1'b0;
    res.frame_end      = 1'b0;
    res.status         = STAT_NONE;
    res.computed_check = 16'd0;

    case (parse_phase)
      PH_SYNC: begin
        // open a frame on a sync byte, drop anything else
        if (rx_byte == SYNC_LONG_A || rx_byte == SYNC_LONG_B || rx_byte == SYNC_SHORT) begin
          long_header_next    = (rx_byte != SYNC_SHORT);
          kind_next           = 2'd0;
          stored_count_next   = 16'd0;
          length_value_next   = 16'd0;
          id_value_next       = 16'd0;
          expected_check_next = 16'd0;
          running_xor_next    = 16'd0;
          pending_high_next   = 8'd0;
          parse_phase_next    = PH_TYPE;
          res.in_frame        = 1'b1;
        end else begin
          res.status = STAT_STRAY;
        end
      end

      PH_TYPE: begin
        // decode the type byte, abort on an unknown one
        res.in_frame     = 1'b1;
        parse_phase_next = PH_HEADER;
        case (rx_byte)
          TYPE_BYTE_0: kind_next = 2'd0;
          TYPE_BYTE_1: kind_next = 2'd1;
          TYPE_BYTE_2: kind_next = 2'd2;
          TYPE_BYTE_3: kind_next = 2'd3;
          default: begin
            res.frame_end    = 1'b1;
            res.status       = STAT_STRAY;
            parse_phase_next = PH_SYNC;
          end
        endcase
      end

      PH_HEADER: begin
        res.in_frame = 1'b1;
        // capture length, id and check word fields
        length_value_next   = field_byte(length_value, 16'(len_off), stored_count, rx_byte);
        id_value_next       = field_byte(id_value, 16'(id_off), stored_count, rx_byte);
        expected_check_next = field_byte(expected_check, 16'd0, stored_count, rx_byte);
        // fold header words into the XOR and snapshot it per word
        if (!stored_count[0]) begin
          pending_high_next = rx_byte;
        end else begin
          if (stored_count[15:1] != 15'd0) begin
            xor_upd = running_xor ^ word_in;
          end
          snap_we = 1'b1;
        end
        running_xor_next  = xor_upd;
        stored_count_next = stored_count + 16'd1;
        // header complete: end on zero length, else rewind XOR to the covered words
        if (stored_count_next >= hdr_bytes) begin
          if (length_value_next == 16'd0) begin
            res.frame_end    = 1'b1;
            res.status       = STAT_ZERO_LEN;
            parse_phase_next = PH_SYNC;
          end else begin
            parse_phase_next = PH_BODY;
            if (length_value_next[15:1] < 15'd2) begin
              running_xor_next = 16'd0;
            end else begin
              n_words = 16'(length_value_next[15:1]) - 16'd2;
              if (n_words >= last_word) begin
                running_xor_next = xor_upd;
              end else begin
                running_xor_next = header_xor_snap[n_words[SNAP_IDX_W-1:0]];
              end
            end
          end
        end
      end

      default: begin
        res.in_frame = 1'b1;
        // fold payload words that fall inside the checked range
        if (!stored_count[0]) begin
          pending_high_next = rx_byte;
        end else if (stored_count[15:1] != 15'd0 &&
                     (16'(stored_count[15:1]) + 16'd2) <= 16'(length_value[15:1])) begin
          xor_upd = running_xor ^ word_in;
        end
        running_xor_next  = xor_upd;
        stored_count_next = (stored_count != 16'hFFFF) ? stored_count + 16'd1 : stored_count;
        end_lhs           = 17'(stored_count_next) + 17'd2;
        // end by length with the check verdict, or abandon when oversize
        if (end_lhs >= 17'(length_value)) begin
          chk                = xor_upd ^ check_seed(kind);
          res.computed_check = chk;
          res.frame_end      = 1'b1;
          if (chk != expected_check) begin
            res.status = STAT_BAD_CHECK;
          end else begin
            res.status = cfg.suppress_good ? STAT_SUPPRESS : STAT_GOOD;
          end
          parse_phase_next = PH_SYNC;
        end else if (stored_count_next >= cfg.max_packet_len) begin
          res.frame_end    = 1'b1;
          res.status       = STAT_OVERSIZE;
          parse_phase_next = PH_SYNC;
        end
      end
    endcase

    res.frame_length = length_value_next;
    res.frame_id     = id_value_next;
    res.type_code    = kind_next;
  end

  // Advance parse state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_SYNC;
      long_header    <= 1'b0;
      kind           <= 2'd0;
      stored_count   <= 16'd0;
      length_value   <= 16'd0;
      id_value       <= 16'd0;
      expected_check <= 16'd0;
      running_xor    <= 16'd0;
      pending_high   <= 8'd0;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      long_header    <= long_header_next;
      kind           <= kind_next;
      stored_count   <= stored_count_next;
      length_value   <= length_value_next;
      id_value       <= id_value_next;
      expected_check <= expected_check_next;
      running_xor    <= running_xor_next;
      pending_high   <= pending_high_next;
    end
  end

  // Store the header XOR snapshot of each completed word
  always_ff @(posedge clk) begin
    if (step && snap_we) begin
      header_xor_snap[snap_idx] <= xor_upd;
    end
  end

endmodule

[hw/rtl/sync_packet_deframer_xor_check_core.sv]
// Top level of the sync packet deframer: handshakes, configuration registers, result register.
// The deframer takes one byte per transaction and returns exactly one result per byte: the
// byte itself tagged with frame status, header fields and, at a frame end by length, the
// computed XOR check. It sustains one byte per clock cycle while out_ready drains the result
// register; a byte passes the input register, then the result register, and the parse state,
// advanced once per accepted byte, sets that rate. Configuration registers are written through
// the cfg channel while no bytes are in flight, a rule the user must keep as the block does
// not enforce it; writes to indexes beyond the register list are accepted and ignored.
module sync_packet_deframer_xor_check_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         echo_byte,
  output logic                               in_frame,
  output logic                               frame_end,
  output logic [2:0]                         status,
  output logic [15:0]                        frame_length,
  output logic [15:0]                        frame_id,
  output logic [1:0]                         type_code,
  output logic [15:0]                        computed_check,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spdxc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [spdxc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spdxc_pkg::*;

  cfg_t        cfg;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        out_full;
  result_t     out_res;
  result_t     res;
  logic        step;

  // Move a byte through the parser when the result register can take it
  assign step      = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || step;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_len_offset  <= 6'd0;
      cfg.short_len_offset <= 4'd0;
      cfg.long_id_offset   <= 6'd0;
      cfg.short_id_offset  <= 4'd0;
      cfg.max_packet_len   <= MAX_PACKET_LEN_RESET;
      cfg.suppress_good    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LONG_LEN_OFFSET:  cfg.long_len_offset  <= cfg_data[5:0];
        REG_SHORT_LEN_OFFSET: cfg.short_len_offset <= cfg_data[3:0];
        REG_LONG_ID_OFFSET:   cfg.long_id_offset   <= cfg_data[5:0];
        REG_SHORT_ID_OFFSET:  cfg.short_id_offset  <= cfg_data[3:0];
        REG_MAX_PACKET_LEN:   cfg.max_packet_len   <= cfg_data[15:0];
        REG_SUPPRESS_GOOD:    cfg.suppress_good    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  spdxc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (step) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign out_valid      = out_full;
  assign echo_byte      = out_res.echo_byte;
  assign in_frame       = out_res.in_frame;
  assign frame_end      = out_res.frame_end;
  assign status         = out_res.status;
  assign frame_length   = out_res.frame_length;
  assign frame_id       = out_res.frame_id;
  assign type_code      = out_res.type_code;
  assign computed_check = out_res.computed_check;

endmodule
